FILE: hdl/lrupr_pkg.sv
`default_nettype none

package lrupr_pkg;

   // Default sizes of the frame table.
   localparam int NUM_FRAMES_DEF = 16;
   localparam int PAGE_BITS_DEF  = 16;

   // Fixed widths of the request and response fields.
   localparam int PAGE_W  = 16;
   localparam int FIDX_W  = 4;
   localparam int FAULT_W = 32;

   // Register block.
   localparam int              CFG_W      = 5;
   localparam logic [CFG_W-1:0] FRAMES_RST = 5'd16;
   localparam int              APB_DATA_W = 32;
   localparam int              APB_ADDR_W = 3;
   localparam int              REG_SEL_W  = APB_ADDR_W - 2;

   localparam logic [REG_SEL_W-1:0] REG_FRAMES_IN_USE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_UPDATE,
      ST_DONE
   } lrupr_state_type;

   typedef struct packed {
      logic               hit;
      logic [FIDX_W-1:0]  frame_index;
      logic               evicted_valid;
      logic [PAGE_W-1:0]  evicted_page;
      logic [FAULT_W-1:0] fault_total;
   } lrupr_rsp_type;

endpackage

`default_nettype wire

FILE: hdl/lrupr_ifs.sv
`default_nettype none

interface lrupr_req_if;
   logic                         valid;
   logic                         ready;
   logic [lrupr_pkg::PAGE_W-1:0] page_number;

   modport source (output valid, output page_number, input ready);
   modport sink (input valid, input page_number, output ready);
endinterface

interface lrupr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [lrupr_pkg::FIDX_W-1:0]  frame_index;
   logic                          evicted_valid;
   logic [lrupr_pkg::PAGE_W-1:0]  evicted_page;
   logic [lrupr_pkg::FAULT_W-1:0] fault_total;

   modport source (output valid, output hit, output frame_index, output evicted_valid,
                   output evicted_page, output fault_total, input ready);
   modport sink (input valid, input hit, input frame_index, input evicted_valid,
                 input evicted_page, input fault_total, output ready);
endinterface

`default_nettype wire

FILE: hdl/lru_page_replacement.sv
`default_nettype none

// Channel   Direction  Handshake          Carries
// req_if    in         valid / ready      page_number
// rsp_if    out        valid / ready      hit, frame_index, evicted_valid, evicted_page,
//                                         fault_total
// csr_*     in         APB write / read   frames_in_use at byte address 0
//
// For each request the frame table memory is swept once to find a hit, an empty frame and
// the oldest frame, and a second time to age the ranks, one entry per cycle through its
// single read port.
// Synchronous reset clears the valid bits, fill pointer, fault counter and handshakes.
// A finished response waits in its register while the next request is taken and
// scanned; the block stalls only when a second response is ready before the first left.

module lru_page_replacement #(
   parameter int NUM_FRAMES = lrupr_pkg::NUM_FRAMES_DEF,
   parameter int PAGE_BITS  = lrupr_pkg::PAGE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   lrupr_req_if.sink                        req_if,
   lrupr_rsp_if.source                      rsp_if,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [lrupr_pkg::APB_ADDR_W-1:0] csr_paddr,
   input  logic [lrupr_pkg::APB_DATA_W-1:0] csr_pwdata,
   output logic                             csr_pready,
   output logic [lrupr_pkg::APB_DATA_W-1:0] csr_prdata
);
   import lrupr_pkg::*;

   localparam int FRAME_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
   localparam int CNT_W   = $clog2(NUM_FRAMES + 1);
   localparam int ENT_W   = PAGE_BITS + CNT_W;
   localparam int MW      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int PW_W    = PAGE_BITS + PAGE_W;
   localparam int FX_W    = FRAME_W + FIDX_W;

   localparam logic [CNT_W-1:0] ALL_FRAMES = CNT_W'(NUM_FRAMES);

   // Register block
   logic [CFG_W-1:0] frames_in_use;

   lrupr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .csr_prdata    (csr_prdata),
      .frames_in_use (frames_in_use)
   );

   // Effective frame count, clamped to 1..NUM_FRAMES.
   logic [MW-1:0]    cfg_wide;
   logic [MW-1:0]    m_wide;
   logic [CNT_W-1:0] m_cnt;

   assign cfg_wide = MW'(frames_in_use);
   always_comb begin
      if (cfg_wide == '0) begin
         m_wide = MW'(1);
      end else if (cfg_wide > MW'(NUM_FRAMES)) begin
         m_wide = MW'(NUM_FRAMES);
      end else begin
         m_wide = cfg_wide;
      end
   end
   assign m_cnt = m_wide[CNT_W-1:0];

   // Frame table memory: page and recency rank of each frame.
   logic [ENT_W-1:0]   mem [NUM_FRAMES];
   logic               rd_en;
   logic [FRAME_W-1:0] rd_addr;
   logic [ENT_W-1:0]   rd_data_ff;
   logic               wr_en;
   logic [FRAME_W-1:0] wr_addr;
   logic [ENT_W-1:0]   wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   logic [PAGE_BITS-1:0] rd_page;
   logic [CNT_W-1:0]     rd_rank;

   assign rd_page = rd_data_ff[ENT_W-1:CNT_W];
   assign rd_rank = rd_data_ff[CNT_W-1:0];

   // Registers
   lrupr_state_type      state_ff, state_in;
   logic [CNT_W-1:0]     issue_ff, issue_in;
   logic                 dat_vld_ff, dat_vld_in;
   logic [FRAME_W-1:0]   dat_idx_ff, dat_idx_in;
   logic [PAGE_BITS-1:0] req_page_ff, req_page_in;
   logic                 hit_ff, hit_in;
   logic [FRAME_W-1:0]   hit_frame_ff, hit_frame_in;
   logic [CNT_W-1:0]     hit_rank_ff, hit_rank_in;
   logic                 empty_found_ff, empty_found_in;
   logic [FRAME_W-1:0]   empty_frame_ff, empty_frame_in;
   logic                 vict_found_ff, vict_found_in;
   logic [FRAME_W-1:0]   vict_frame_ff, vict_frame_in;
   logic [CNT_W-1:0]     vict_rank_ff, vict_rank_in;
   logic [PAGE_BITS-1:0] vict_page_ff, vict_page_in;
   logic [FRAME_W-1:0]   tgt_ff, tgt_in;
   logic [CNT_W-1:0]     old_rank_ff, old_rank_in;
   logic                 evict_ff, evict_in;
   logic [FRAME_W-1:0]   fill_ff, fill_in;
   logic [NUM_FRAMES-1:0] valid_ff, valid_in;
   logic [FAULT_W-1:0]   fault_ff, fault_in;
   lrupr_rsp_type        rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Helpers
   logic [PW_W-1:0]    req_wide;
   logic [PW_W-1:0]    vict_wide;
   logic [FX_W-1:0]    tgt_wide;
   logic               cur_valid;
   logic               cur_below;
   logic [CNT_W-1:0]   fp_cnt;
   logic [FRAME_W-1:0] fp;
   logic [CNT_W-1:0]   fp_next;
   logic [FRAME_W-1:0] fill_adv;

   assign req_wide  = PW_W'(req_if.page_number);
   assign vict_wide = PW_W'(vict_page_ff);
   assign tgt_wide  = FX_W'(tgt_ff);
   assign cur_valid = valid_ff[dat_idx_ff];
   assign cur_below = CNT_W'(dat_idx_ff) < m_cnt;

   // A stale fill pointer beyond the frames in use wraps to frame zero.
   assign fp_cnt   = (CNT_W'(fill_ff) >= m_cnt) ? '0 : CNT_W'(fill_ff);
   assign fp       = fp_cnt[FRAME_W-1:0];
   assign fp_next  = fp_cnt + CNT_W'(1);
   assign fill_adv = (fp_next >= m_cnt) ? '0 : fp_next[FRAME_W-1:0];

   always_comb begin
      state_in       = state_ff;
      issue_in       = issue_ff;
      dat_vld_in     = 1'b0;
      dat_idx_in     = issue_ff[FRAME_W-1:0];
      req_page_in    = req_page_ff;
      hit_in         = hit_ff;
      hit_frame_in   = hit_frame_ff;
      hit_rank_in    = hit_rank_ff;
      empty_found_in = empty_found_ff;
      empty_frame_in = empty_frame_ff;
      vict_found_in  = vict_found_ff;
      vict_frame_in  = vict_frame_ff;
      vict_rank_in   = vict_rank_ff;
      vict_page_in   = vict_page_ff;
      tgt_in         = tgt_ff;
      old_rank_in    = old_rank_ff;
      evict_in       = evict_ff;
      fill_in        = fill_ff;
      valid_in       = valid_ff;
      fault_in       = fault_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff;
      rd_en          = 1'b0;
      rd_addr        = issue_ff[FRAME_W-1:0];
      wr_en          = 1'b0;
      wr_addr        = dat_idx_ff;
      wr_data        = rd_data_ff;
      req_if.ready   = 1'b0;

      if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_if.ready = 1'b1;
            if (req_if.valid) begin
               req_page_in    = req_wide[PAGE_BITS-1:0];
               hit_in         = 1'b0;
               empty_found_in = 1'b0;
               vict_found_in  = 1'b0;
               issue_in       = '0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue_ff != ALL_FRAMES) begin
               rd_en      = 1'b1;
               dat_vld_in = 1'b1;
               issue_in   = issue_ff + CNT_W'(1);
            end
            if (dat_vld_ff) begin
               if (cur_valid && (rd_page == req_page_ff) && !hit_ff) begin
                  hit_in       = 1'b1;
                  hit_frame_in = dat_idx_ff;
                  hit_rank_in  = rd_rank;
               end
               if (cur_below && !cur_valid && !empty_found_ff) begin
                  empty_found_in = 1'b1;
                  empty_frame_in = dat_idx_ff;
               end
               // Strictly older wins, so the lowest index keeps a tie.
               if (cur_below && cur_valid && (!vict_found_ff || (rd_rank > vict_rank_ff))) begin
                  vict_found_in = 1'b1;
                  vict_frame_in = dat_idx_ff;
                  vict_rank_in  = rd_rank;
                  vict_page_in  = rd_page;
               end
            end
            if (issue_ff == ALL_FRAMES) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            evict_in = 1'b0;
            if (hit_ff) begin
               tgt_in      = hit_frame_ff;
               old_rank_in = hit_rank_ff;
            end else begin
               fault_in = (fault_ff != '1) ? fault_ff + FAULT_W'(1) : fault_ff;
               if (!valid_ff[fp]) begin
                  tgt_in       = fp;
                  fill_in      = fill_adv;
                  valid_in[fp] = 1'b1;
                  old_rank_in  = ALL_FRAMES;
               end else begin
                  fill_in = fp;
                  if (empty_found_ff) begin
                     tgt_in                   = empty_frame_ff;
                     valid_in[empty_frame_ff] = 1'b1;
                     old_rank_in              = ALL_FRAMES;
                  end else begin
                     tgt_in      = vict_frame_ff;
                     old_rank_in = vict_rank_ff;
                     evict_in    = 1'b1;
                  end
               end
            end
            issue_in = '0;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (issue_ff != ALL_FRAMES) begin
               rd_en      = 1'b1;
               dat_vld_in = 1'b1;
               issue_in   = issue_ff + CNT_W'(1);
            end
            // Write-back trails the read by one entry, so the two never collide.
            if (dat_vld_ff) begin
               wr_en = 1'b1;
               if (dat_idx_ff == tgt_ff) begin
                  wr_data = {req_page_ff, CNT_W'(0)};
               end else if (cur_valid && (rd_rank < old_rank_ff)) begin
                  wr_data = {rd_page, rd_rank + CNT_W'(1)};
               end
            end
            if (issue_ff == ALL_FRAMES) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_in.hit           = hit_ff;
               rsp_in.frame_index   = tgt_wide[FIDX_W-1:0];
               rsp_in.evicted_valid = evict_ff;
               rsp_in.evicted_page  = evict_ff ? vict_wide[PAGE_W-1:0] : '0;
               rsp_in.fault_total   = fault_ff;
               rsp_valid_in         = 1'b1;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dat_vld_ff   <= 1'b0;
         fill_ff      <= '0;
         valid_ff     <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dat_vld_ff   <= dat_vld_in;
         fill_ff      <= fill_in;
         valid_ff     <= valid_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff       <= issue_in;
      dat_idx_ff     <= dat_idx_in;
      req_page_ff    <= req_page_in;
      hit_ff         <= hit_in;
      hit_frame_ff   <= hit_frame_in;
      hit_rank_ff    <= hit_rank_in;
      empty_found_ff <= empty_found_in;
      empty_frame_ff <= empty_frame_in;
      vict_found_ff  <= vict_found_in;
      vict_frame_ff  <= vict_frame_in;
      vict_rank_ff   <= vict_rank_in;
      vict_page_ff   <= vict_page_in;
      tgt_ff         <= tgt_in;
      old_rank_ff    <= old_rank_in;
      evict_ff       <= evict_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.hit           = rsp_ff.hit;
   assign rsp_if.frame_index   = rsp_ff.frame_index;
   assign rsp_if.evicted_valid = rsp_ff.evicted_valid;
   assign rsp_if.evicted_page  = rsp_ff.evicted_page;
   assign rsp_if.fault_total   = rsp_ff.fault_total;

   // The fault counter only counts up or holds.
   a_fault_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> fault_ff >= $past(fault_ff))
      else $error("fault counter went down");

   // Once loaded, a frame stays resident.
   a_valid_sticky: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (valid_ff & $past(valid_ff)) == $past(valid_ff))
      else $error("frame valid bit cleared");

   // An eviction is only ever reported for a miss.
   a_evict_is_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.evicted_valid |-> !rsp_ff.hit)
      else $error("eviction reported on a hit");

   // A miss has always been counted before its response goes out.
   a_miss_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.hit |-> rsp_ff.fault_total != '0)
      else $error("miss response with zero fault total");

endmodule

`default_nettype wire

FILE: hdl/lrupr_csr.sv
`default_nettype none

module lrupr_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [lrupr_pkg::APB_ADDR_W-1:0]  csr_paddr,
   input  logic [lrupr_pkg::APB_DATA_W-1:0]  csr_pwdata,
   output logic                              csr_pready,
   output logic [lrupr_pkg::APB_DATA_W-1:0]  csr_prdata,
   output logic [lrupr_pkg::CFG_W-1:0]       frames_in_use
);
   import lrupr_pkg::*;

   logic [CFG_W-1:0]     frames_ff;
   logic [CFG_W-1:0]     frames_in;
   logic [REG_SEL_W-1:0] reg_sel;
   logic                 wr_strobe;

   assign reg_sel   = csr_paddr[APB_ADDR_W-1:2];
   assign wr_strobe = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      frames_in = frames_ff;
      if (wr_strobe && (reg_sel == REG_FRAMES_IN_USE)) begin
         frames_in = csr_pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RST;
      end else begin
         frames_ff <= frames_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (reg_sel == REG_FRAMES_IN_USE) begin
         csr_prdata = APB_DATA_W'(frames_ff);
      end
   end

   assign csr_pready    = 1'b1;
   assign frames_in_use = frames_ff;

endmodule

`default_nettype wire
